@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

@@ hdl/sha256_pkg.sv @@
// Package with SHA-256 constants, types and round functions.
`default_nettype none
package sha256_pkg;
	localparam int unsigned BlockBytes = 64;
	localparam int unsigned LengthPos = 56;
	localparam int unsigned QueueDepth = 4;

	typedef logic [31:0] word_t;

	// Queue entry from front to back: a byte, an end marker, or both.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       end_of_message;
	} entry_t;

	localparam word_t KInit [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t KRound [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
		32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
		32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
		32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
		32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
		32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
		32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
		32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
		32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_ROUND,
		ST_FOLD,
		ST_PAD,
		ST_EMIT
	} state_t;

	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t sig0(input word_t p);
		sig0 = rotr(p, 7) ^ rotr(p, 18) ^ (p >> 3);
	endfunction

	function automatic word_t sig1(input word_t q);
		sig1 = rotr(q, 17) ^ rotr(q, 19) ^ (q >> 10);
	endfunction

	function automatic word_t bsig0(input word_t a);
		bsig0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
	endfunction

	function automatic word_t bsig1(input word_t e);
		bsig1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
	endfunction
endpackage
`default_nettype wire

@@ hdl/sha256_message_hasher_top.sv @@
// Top level of the streaming SHA-256 message hasher.
//
// Input channel s_*: one word per message byte. s_tdata carries the byte,
// s_tuser says the word carries a byte, s_tlast marks the final word of a
// message. A word with s_tlast and no byte ends the message without adding
// one, which is how an empty message is hashed. Words with neither flag
// are taken and ignored.
// Output channel m_*: eight digest words per message, word 0 first; m_tlast
// marks word 7.
// A four-entry queue decouples the input from the hashing core. While it
// is loading, the core takes one byte per cycle from the queue; on each
// full block it then runs the rounds and a fold step in the single round
// unit and takes no bytes. The digest words follow the rounds of the final
// block, which is an extra block when the padding needs a second one.
// A stalled receiver holds the digest words; the queue then fills and
// s_tready falls. Reset clears the queue and loads the initial hash values.
`default_nettype none
module sha256_message_hasher_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] data_byte
	input  wire         s_tuser,   // [0] has_byte
	input  wire         s_tlast,
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_number, zeros above
	output logic        m_tlast
);
	import sha256_pkg::*;

	logic   q_valid, q_ready;
	entry_t q_entry;
	logic [34:0] core_data;

	sha256_front u_front (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.q_valid(q_valid), .q_ready(q_ready), .q_entry(q_entry)
	);

	sha256_core u_core (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_entry(q_entry),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(core_data),
		.m_tlast(m_tlast)
	);

	assign m_tdata = {5'b0, core_data[34:0]};
endmodule
`default_nettype wire

@@ hdl/sha256_front.sv @@
// Front end: accepts input words, drops empty items, queues the rest.
`default_nettype none
module sha256_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  s_tvalid,
	output logic                 s_tready,
	input  wire  [7:0]           s_tdata,
	input  wire                  s_tuser,
	input  wire                  s_tlast,
	output logic                 q_valid,
	input  wire                  q_ready,
	output sha256_pkg::entry_t   q_entry
);
	import sha256_pkg::*;
`include "assert_macros.svh"

	localparam int unsigned PtrW = $clog2(QueueDepth);

	entry_t            mem_q [QueueDepth];
	logic [PtrW-1:0]   wr_q, rd_q;
	logic [PtrW:0]     count_q;
	logic              push, pop;

	assign s_tready = (count_q != (PtrW+1)'(QueueDepth));
	// Items with neither a byte nor an end mark change nothing.
	assign push = s_tvalid && s_tready && (s_tuser || s_tlast);
	assign q_valid = (count_q != '0);
	assign pop = q_valid && q_ready;
	assign q_entry = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= '{data_byte: s_tdata, has_byte: s_tuser, end_of_message: s_tlast};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			count_q <= count_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
		end
	end

	`ASSERT_NEVER(a_no_overflow, clk, arst_n, push && !pop && count_q == (PtrW+1)'(QueueDepth), "queue overflow")
	`ASSERT_NEVER(a_no_underflow, clk, arst_n, pop && count_q == '0, "queue underflow")
	`ASSERT_IMPL(a_count_tracks, clk, arst_n, (push && !pop) |=> count_q == $past(count_q) + 1'b1, "count mismatch")
endmodule
`default_nettype wire

@@ hdl/sha256_core.sv @@
// Back end: block buffer, padding, 64-round compression and digest output.
`default_nettype none
module sha256_core (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  q_valid,
	output logic                 q_ready,
	input  sha256_pkg::entry_t   q_entry,
	output logic                 m_tvalid,
	input  wire                  m_tready,
	output logic [34:0]          m_tdata,
	output logic                 m_tlast
);
	import sha256_pkg::*;
`include "assert_macros.svh"

	word_t       h_q [8];
	word_t       w_q [16];   // message schedule window, block word 0 at index 0
	word_t       v_q [8];
	logic [5:0]  fill_q;     // bytes held
	logic [60:0] count_q;
	logic [5:0]  round_q;
	logic        last_blk_q; // block in flight is the final one
	logic        len_pend_q; // a length-only block is still to come
	logic        pad_head_q; // the extra block must start with the 0x80 marker
	logic [2:0]  oidx_q;
	state_t      state_q, state_d;

	word_t       t1, t2, w_next;
	logic        take;

	assign w_next = w_q[0] + sig0(w_q[1]) + w_q[9] + sig1(w_q[14]);
	assign t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ KRound[round_q] + w_q[0];
	assign t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

	assign q_ready = (state_q == ST_LOAD);
	assign take = q_valid && q_ready;
	assign m_tvalid = (state_q == ST_EMIT);
	assign m_tdata = {oidx_q, h_q[oidx_q]};
	assign m_tlast = (oidx_q == 3'd7);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (take) begin
					if (q_entry.has_byte && fill_q == 6'd63) state_d = ST_ROUND;
					else if (q_entry.end_of_message) state_d = ST_PAD;
				end
			end
			ST_ROUND: if (round_q == 6'd63) state_d = ST_FOLD;
			ST_FOLD: begin
				if (last_blk_q) state_d = ST_EMIT;
				else if (len_pend_q) state_d = ST_PAD;
				else state_d = ST_LOAD;
			end
			ST_PAD: state_d = ST_ROUND;
			ST_EMIT: if (m_tready && oidx_q == 3'd7) state_d = ST_LOAD;
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_LOAD;
		else state_q <= state_d;
	end

	// Writes one byte into the schedule window at the given fill position.
	function automatic void put_byte(ref word_t w [16], input logic [5:0] pos,
			input logic [7:0] b);
		case (pos[1:0])
			2'd0: w[pos[5:2]][31:24] = b;
			2'd1: w[pos[5:2]][23:16] = b;
			2'd2: w[pos[5:2]][15:8] = b;
			default: w[pos[5:2]][7:0] = b;
		endcase
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) h_q[i] <= KInit[i];
			for (int i = 0; i < 16; i++) w_q[i] <= '0;
			for (int i = 0; i < 8; i++) v_q[i] <= '0;
			fill_q <= '0;
			count_q <= '0;
			round_q <= '0;
			last_blk_q <= 1'b0;
			len_pend_q <= 1'b0;
			oidx_q <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (take) begin
						logic [5:0] f;
						word_t wt [16];
						f = fill_q;
						wt = w_q;
						if (q_entry.has_byte) begin
							put_byte(wt, f, q_entry.data_byte);
							count_q <= count_q + 61'd1;
							f = f + 6'd1;
						end
						if (q_entry.end_of_message && !(q_entry.has_byte && fill_q == 6'd63)) begin
							// Marker and zero tail of the block.
							put_byte(wt, f, 8'h80);
							for (int i = 0; i < 16; i++) begin
								if (6'(i) > f[5:2]) wt[i] = '0;
							end
							case (f[1:0])
								2'd0: wt[f[5:2]][23:0] = '0;
								2'd1: wt[f[5:2]][15:0] = '0;
								2'd2: wt[f[5:2]][7:0] = '0;
								default: ;
							endcase
							len_pend_q <= (f >= 6'(LengthPos));
							last_blk_q <= (f < 6'(LengthPos));
						end else if (q_entry.end_of_message) begin
							// Full block now, the marker goes in a later block.
							len_pend_q <= 1'b1;
							last_blk_q <= 1'b0;
						end
						w_q <= wt;
						fill_q <= f;
						if (q_entry.has_byte && fill_q == 6'd63) begin
							for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
							round_q <= '0;
							fill_q <= '0;
						end
					end
				end
				ST_PAD: begin
					// Only the final block carries the bit length.
					if (last_blk_q) begin
						w_q[14] <= {count_q[60:29]};
						w_q[15] <= {count_q[28:0], 3'b000};
					end
					for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
					round_q <= '0;
				end
				ST_ROUND: begin
					v_q[7] <= v_q[6];
					v_q[6] <= v_q[5];
					v_q[5] <= v_q[4];
					v_q[4] <= v_q[3] + t1;
					v_q[3] <= v_q[2];
					v_q[2] <= v_q[1];
					v_q[1] <= v_q[0];
					v_q[0] <= t1 + t2;
					for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
					w_q[15] <= w_next;
					round_q <= round_q + 6'd1;
				end
				ST_FOLD: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					fill_q <= '0;
					if (len_pend_q && !last_blk_q) begin
						// Next block holds padding and the length only.
						last_blk_q <= 1'b1;
						len_pend_q <= 1'b0;
						for (int i = 1; i < 16; i++) w_q[i] <= '0;
						w_q[0] <= pad_head_q ? 32'h8000_0000 : 32'h0;
					end else if (!last_blk_q) begin
						for (int i = 0; i < 16; i++) w_q[i] <= '0;
					end
				end
				ST_EMIT: begin
					if (m_tready) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							for (int i = 0; i < 8; i++) h_q[i] <= KInit[i];
							for (int i = 0; i < 16; i++) w_q[i] <= '0;
							count_q <= '0;
							fill_q <= '0;
							last_blk_q <= 1'b0;
							len_pend_q <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Set when the end came on a byte that filled the block, so the marker
	// opens the extra block.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pad_head_q <= 1'b0;
		else if (take && q_entry.end_of_message)
			pad_head_q <= q_entry.has_byte && fill_q == 6'd63;
	end

	// A pad step is followed by the rounds, starting from round 0.
	`ASSERT_IMPL(a_round_len, clk, arst_n, (state_q == ST_PAD) |=> (state_q == ST_ROUND && round_q == '0), "pad must start rounds")
	`ASSERT_IMPL(a_emit_hold, clk, arst_n, (m_tvalid && !m_tready) |=> $stable(oidx_q), "index moved under stall")
	`ASSERT_NEVER(a_no_take_busy, clk, arst_n, q_ready && state_q != ST_LOAD, "ready outside load")
endmodule
`default_nettype wire
